### rtl/core/spt_pkg.sv
`timescale 1ns / 1ps

package spt_pkg;

  // Action codes carried by an input transfer.
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_PARAM = 2'd1;
  localparam logic [1:0] ACT_REPLY = 2'd2;
  localparam logic [1:0] ACT_TICK  = 2'd3;

  // Result kinds and status codes.
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_PARAM  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  // Which result the datapath builds when the controller asks for one.
  typedef enum logic [2:0] {
    SEL_SYNC   = 3'd0,
    SEL_ID     = 3'd1,
    SEL_LEN    = 3'd2,
    SEL_INSTR  = 3'd3,
    SEL_DATA   = 3'd4,
    SEL_CSUM   = 3'd5,
    SEL_STATUS = 3'd6,
    SEL_PARAM  = 3'd7
  } emit_sel_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] target_id;
    logic [7:0] instruction;
    logic [4:0] cmd_param_count;
    logic [4:0] reply_param_count;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic      capture;
    logic      exec;
    logic      emit;
    emit_sel_t sel;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic [1:0] action;
    logic       send_go;
    logic       reply_done;
    logic       tick_expired;
    logic       cmd_zero;
    logic       stat_more;
    logic       param_last;
  } dp_stat_t;

endpackage

### rtl/core/spt_ifs.sv
`timescale 1ns / 1ps

interface spt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] target_id;
  logic [7:0] instruction;
  logic [4:0] cmd_param_count;
  logic [4:0] reply_param_count;
  logic [7:0] data_byte;

  modport source (output valid, action, target_id, instruction, cmd_param_count,
                  reply_param_count, data_byte, input ready);
  modport sink (input valid, action, target_id, instruction, cmd_param_count,
                reply_param_count, data_byte, output ready);
endinterface

interface spt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, kind, out_byte, status, last, input ready);
  modport sink (input valid, kind, out_byte, status, last, output ready);
endinterface

interface spt_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] timeout_ticks;

  modport source (output valid, timeout_ticks, input ready);
  modport sink (input valid, timeout_ticks, output ready);
endinterface

### rtl/core/spt_dp.sv
`timescale 1ns / 1ps

module spt_dp import spt_pkg::*; #(
  parameter int CMAX   = 16,
  parameter int RDEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  in_item_t    in_item,
  input  dp_cmd_t     cmd,
  output dp_stat_t    st,
  input  logic        out_ready,
  output logic        out_valid,
  output out_item_t   out_item
);

  localparam int CL_W = $clog2(CMAX + 1);
  localparam int EC_W = $clog2(RDEPTH + 1);
  localparam int AW   = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
  localparam int IX_W = $clog2(RDEPTH + 7);

  localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
  localparam logic [7:0]  SUM_GOOD      = 8'hFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd80;
  localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEND = 2'd1,
    PH_RECV = 2'd2
  } phase_t;

  logic [15:0]     timeout_r, timeout_nxt;
  in_item_t        in_r, in_nxt;
  phase_t          phase_r, phase_nxt;
  logic [7:0]      tx_sum_r, tx_sum_nxt;
  logic [CL_W-1:0] cmd_left_r, cmd_left_nxt;
  logic [IX_W-1:0] rx_index_r, rx_index_nxt;
  logic [7:0]      rx_sum_r, rx_sum_nxt;
  logic            rx_bad_r, rx_bad_nxt;
  logic [7:0]      saved_id_r, saved_id_nxt;
  logic [EC_W-1:0] exp_cnt_r, exp_cnt_nxt;
  logic [15:0]     elapsed_r, elapsed_nxt;
  logic [1:0]      stat_r, stat_nxt;
  logic [AW-1:0]   rd_addr_r, rd_addr_nxt;
  logic [7:0]      rd_data_r;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;
  logic [7:0]      mem_r [RDEPTH];

  logic [CL_W-1:0] ccount_sat;
  logic [EC_W-1:0] rcount_sat;
  logic [IX_W-1:0] total;
  logic [IX_W-1:0] idx_inc;
  logic            rx_final;
  logic [7:0]      rx_sum_upd;
  logic            hdr_bad;
  logic            rx_bad_upd;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [15:0]     elapsed_inc;
  logic            tick_hit;
  logic            param_last;

  always_comb begin
    ccount_sat = (in_r.cmd_param_count > 5'(CMAX)) ? CL_W'(CMAX)
                                                    : CL_W'(in_r.cmd_param_count);
    rcount_sat = (in_r.reply_param_count > 5'(RDEPTH)) ? EC_W'(RDEPTH)
                                                        : EC_W'(in_r.reply_param_count);
    total      = IX_W'(exp_cnt_r) + IX_W'(6);
    idx_inc    = rx_index_r + IX_W'(1);
    rx_final   = (idx_inc >= total);
    rx_sum_upd = (rx_index_r >= IX_W'(2)) ? (rx_sum_r + in_r.data_byte) : rx_sum_r;
    case (rx_index_r) inside
      IX_W'(0), IX_W'(1): hdr_bad = (in_r.data_byte != SYNC_BYTE);
      IX_W'(2):           hdr_bad = (in_r.data_byte != saved_id_r);
      IX_W'(3):           hdr_bad = (in_r.data_byte != (8'(exp_cnt_r) + 8'd2));
      IX_W'(4):           hdr_bad = (in_r.data_byte != 8'd0);
      default:            hdr_bad = 1'b0;
    endcase
    rx_bad_upd  = rx_bad_r | hdr_bad;
    wr_en       = cmd.exec && (in_r.action == ACT_REPLY) && (phase_r == PH_RECV) &&
                  (rx_index_r >= IX_W'(5)) && (idx_inc < total);
    wr_addr     = AW'(rx_index_r - IX_W'(5));
    elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : (elapsed_r + 16'd1);
    tick_hit    = (elapsed_inc >= timeout_r);
    param_last  = ((EC_W'(rd_addr_r) + EC_W'(1)) == exp_cnt_r);
  end

  always_comb begin
    timeout_nxt   = timeout_r;
    in_nxt        = in_r;
    phase_nxt     = phase_r;
    tx_sum_nxt    = tx_sum_r;
    cmd_left_nxt  = cmd_left_r;
    rx_index_nxt  = rx_index_r;
    rx_sum_nxt    = rx_sum_r;
    rx_bad_nxt    = rx_bad_r;
    saved_id_nxt  = saved_id_r;
    exp_cnt_nxt   = exp_cnt_r;
    elapsed_nxt   = elapsed_r;
    stat_nxt      = stat_r;
    rd_addr_nxt   = rd_addr_r;
    out_nxt       = out_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;

    if (cfg_we) begin
      timeout_nxt = cfg_data;
    end
    if (cmd.capture) begin
      in_nxt = in_item;
    end

    if (cmd.exec) begin
      case (in_r.action)
        ACT_START: begin
          saved_id_nxt = in_r.target_id;
          exp_cnt_nxt  = rcount_sat;
          cmd_left_nxt = ccount_sat;
          rx_index_nxt = '0;
          rx_sum_nxt   = '0;
          rx_bad_nxt   = 1'b0;
          elapsed_nxt  = '0;
          tx_sum_nxt   = '0;
          phase_nxt    = PH_SEND;
        end
        ACT_PARAM: begin
          if (phase_r == PH_SEND && cmd_left_r != '0) begin
            cmd_left_nxt = cmd_left_r - CL_W'(1);
          end
        end
        ACT_REPLY: begin
          if (phase_r == PH_RECV) begin
            rx_sum_nxt   = rx_sum_upd;
            rx_bad_nxt   = rx_bad_upd;
            rx_index_nxt = idx_inc;
            if (rx_final) begin
              rx_bad_nxt = rx_bad_upd | (rx_sum_upd != SUM_GOOD);
              phase_nxt  = PH_IDLE;
              stat_nxt   = (rx_bad_upd || rx_sum_upd != SUM_GOOD) ? ST_INVALID : ST_OK;
            end
          end
        end
        default: begin
          if (phase_r != PH_IDLE) begin
            elapsed_nxt = elapsed_inc;
            if (tick_hit) begin
              phase_nxt = PH_IDLE;
              stat_nxt  = ST_TIMEOUT;
            end
          end
        end
      endcase
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_nxt.kind     = KIND_TX;
      out_nxt.out_byte = 8'd0;
      out_nxt.status   = ST_OK;
      out_nxt.last     = cmd.last;
      case (cmd.sel)
        SEL_SYNC: out_nxt.out_byte = SYNC_BYTE;
        SEL_ID: begin
          out_nxt.out_byte = saved_id_r;
          tx_sum_nxt       = tx_sum_r + saved_id_r;
        end
        SEL_LEN: begin
          out_nxt.out_byte = 8'(cmd_left_r) + 8'd2;
          tx_sum_nxt       = tx_sum_r + 8'(cmd_left_r) + 8'd2;
        end
        SEL_INSTR: begin
          out_nxt.out_byte = in_r.instruction;
          tx_sum_nxt       = tx_sum_r + in_r.instruction;
        end
        SEL_DATA: begin
          out_nxt.out_byte = in_r.data_byte;
          tx_sum_nxt       = tx_sum_r + in_r.data_byte;
        end
        SEL_CSUM: begin
          out_nxt.out_byte = ~tx_sum_r;
          phase_nxt        = PH_RECV;
        end
        SEL_STATUS: begin
          out_nxt.kind   = KIND_STATUS;
          out_nxt.status = stat_r;
          rd_addr_nxt    = '0;
        end
        default: begin
          out_nxt.kind     = KIND_PARAM;
          out_nxt.out_byte = rd_data_r;
          if (!param_last) begin
            rd_addr_nxt = rd_addr_r + AW'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RESET;
      phase_r     <= PH_IDLE;
      tx_sum_r    <= '0;
      cmd_left_r  <= '0;
      rx_index_r  <= '0;
      rx_sum_r    <= '0;
      rx_bad_r    <= 1'b0;
      saved_id_r  <= '0;
      exp_cnt_r   <= '0;
      elapsed_r   <= '0;
      stat_r      <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      timeout_r   <= timeout_nxt;
      phase_r     <= phase_nxt;
      tx_sum_r    <= tx_sum_nxt;
      cmd_left_r  <= cmd_left_nxt;
      rx_index_r  <= rx_index_nxt;
      rx_sum_r    <= rx_sum_nxt;
      rx_bad_r    <= rx_bad_nxt;
      saved_id_r  <= saved_id_nxt;
      exp_cnt_r   <= exp_cnt_nxt;
      elapsed_r   <= elapsed_nxt;
      stat_r      <= stat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r      <= in_nxt;
    rd_addr_r <= rd_addr_nxt;
    out_r     <= out_nxt;
  end

  // Reply parameter buffer: one write port, one registered read port. The read
  // follows the next address so the data is ready the cycle a parameter goes out.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= in_r.data_byte;
    end
    rd_data_r <= mem_r[rd_addr_nxt];
  end

  always_comb begin
    st.out_free     = !out_valid_r || out_ready;
    st.action       = in_r.action;
    st.send_go      = (phase_r == PH_SEND);
    st.reply_done   = (phase_r == PH_RECV) && rx_final;
    st.tick_expired = (phase_r != PH_IDLE) && tick_hit;
    st.cmd_zero     = (cmd_left_r == '0);
    st.stat_more    = (stat_r == ST_OK) && (exp_cnt_r != '0);
    st.param_last   = param_last;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### rtl/core/spt_ctrl.sv
`timescale 1ns / 1ps

module spt_ctrl import spt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t st,
  output dp_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_EXEC  = 11'b000_0000_0010,
    S_SYNC1 = 11'b000_0000_0100,
    S_SYNC2 = 11'b000_0000_1000,
    S_ID    = 11'b000_0001_0000,
    S_LEN   = 11'b000_0010_0000,
    S_INSTR = 11'b000_0100_0000,
    S_DATA  = 11'b000_1000_0000,
    S_CSUM  = 11'b001_0000_0000,
    S_STAT  = 11'b010_0000_0000,
    S_PARAM = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.emit    = 1'b0;
    cmd.sel     = SEL_SYNC;
    cmd.last    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (st.action)
          ACT_START: state_nxt = S_SYNC1;
          ACT_PARAM: state_nxt = st.send_go ? S_DATA : S_IDLE;
          ACT_REPLY: state_nxt = st.reply_done ? S_STAT : S_IDLE;
          default:   state_nxt = st.tick_expired ? S_STAT : S_IDLE;
        endcase
      end
      S_SYNC1: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_SYNC;
          state_nxt = S_SYNC2;
        end
      end
      S_SYNC2: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_SYNC;
          state_nxt = S_ID;
        end
      end
      S_ID: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_ID;
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_LEN;
          state_nxt = S_INSTR;
        end
      end
      S_INSTR: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_INSTR;
          cmd.last  = !st.cmd_zero;
          state_nxt = st.cmd_zero ? S_CSUM : S_IDLE;
        end
      end
      S_DATA: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_DATA;
          cmd.last  = !st.cmd_zero;
          state_nxt = st.cmd_zero ? S_CSUM : S_IDLE;
        end
      end
      S_CSUM: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_CSUM;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_STAT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_STATUS;
          cmd.last  = !st.stat_more;
          state_nxt = st.stat_more ? S_PARAM : S_IDLE;
        end
      end
      S_PARAM: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_PARAM;
          cmd.last  = st.param_last;
          state_nxt = st.param_last ? S_IDLE : S_PARAM;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/servo_packet_transaction.sv
`timescale 1ns / 1ps

// Servo bus transaction engine for a protocol 1.0 style packet exchange.
// Input channel (in_ch): each transfer is a start command, a command
// parameter byte, a received reply byte or a time tick. A start produces the
// header FF FF id len instr; the inverted checksum follows the last command
// parameter, else the header. The final reply byte gives a status transfer and,
// for a good reply, the buffered reply parameters. Ticks after the timeout limit
// produce a timeout status. The last flag marks the final result of each input.
// Result channel (out_ch): one registered output stage; results leave at one
// per cycle while the receiver is ready.
// Configuration (cfg_ch): the timeout limit in ticks, always ready; write it
// only while no transaction traffic is in flight.
// Flow: each input is accepted in the idle state and executed in the next
// state (accept, then execute); the controller's emit states then produce its
// results, if any, one per cycle while the output stage is free. The first
// result of an input is registered after the execute step. Input ready is held
// low while results are being produced, so a stalled receiver stalls intake.
// Reset (rst_n, synchronous): idle phase, timeout limit 80, output empty.

module servo_packet_transaction import spt_pkg::*; #(
  parameter int MAX_CMD_PARAMS   = 16,
  parameter int MAX_REPLY_PARAMS = 16
) (
  input logic        clk,
  input logic        rst_n,
  spt_cfg_if.sink    cfg_ch,
  spt_in_if.sink     in_ch,
  spt_out_if.source  out_ch
);

  // A five-bit count field never exceeds 31, so larger limits act as 31.
  localparam int CNT_FIELD_MAX = 31;
  localparam int CMAX   = (MAX_CMD_PARAMS < CNT_FIELD_MAX) ? MAX_CMD_PARAMS : CNT_FIELD_MAX;
  localparam int RDEPTH = (MAX_REPLY_PARAMS < CNT_FIELD_MAX) ? MAX_REPLY_PARAMS
                                                             : CNT_FIELD_MAX;

  in_item_t  in_item;
  out_item_t out_item;
  dp_cmd_t   cmd;
  dp_stat_t  st;
  logic      in_ready;
  logic      out_valid;

  always_comb begin
    in_item.action            = in_ch.action;
    in_item.target_id         = in_ch.target_id;
    in_item.instruction       = in_ch.instruction;
    in_item.cmd_param_count   = in_ch.cmd_param_count;
    in_item.reply_param_count = in_ch.reply_param_count;
    in_item.data_byte         = in_ch.data_byte;
  end

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  spt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  spt_dp #(
    .CMAX   (CMAX),
    .RDEPTH (RDEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.timeout_ticks),
    .in_item   (in_item),
    .cmd       (cmd),
    .st        (st),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign out_ch.valid    = out_valid;
  assign out_ch.kind     = out_item.kind;
  assign out_ch.out_byte = out_item.out_byte;
  assign out_ch.status   = out_item.status;
  assign out_ch.last     = out_item.last;

  // The controller only loads the output stage when it is free.
  a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_free)
    else $error("result loaded into an occupied output stage");

  // No result is produced while a new input transfer can be taken.
  a_no_emit_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !cmd.emit)
    else $error("result produced while accepting input");

  // The checksum always closes its run.
  a_csum_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.sel == SEL_CSUM) |-> cmd.last)
    else $error("checksum not marked last");

  // A failed or timed-out transaction reports a single status result.
  a_bad_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == KIND_STATUS && out_ch.status != ST_OK) |-> out_ch.last)
    else $error("error status followed by further results");

endmodule

### tb/tb_servo_packet_transaction.sv
`timescale 1ns / 1ps

import spt_pkg::*;

// Tracks one servo bus exchange as the block should see it, and checks
// every result transfer against the results that are still owed.
class servo_bus_tracker;
  typedef enum logic [1:0] {LINK_IDLE, LINK_SEND, LINK_RECV} link_phase_e;

  link_phase_e phase;
  logic [15:0] limit;
  logic [15:0] ticks;
  logic [7:0]  tx_sum;
  logic [7:0]  rx_sum;
  logic [7:0]  peer_id;
  int          cmd_due;
  int          rx_pos;
  int          reply_len;
  bit          rx_bad;
  logic [7:0]  reply_buf [16];
  out_item_t   results_due [$];
  int          errors;

  function new();
    limit     = 16'd80;
    phase     = LINK_IDLE;
    ticks     = '0;
    tx_sum    = '0;
    rx_sum    = '0;
    peer_id   = '0;
    cmd_due   = 0;
    rx_pos    = 0;
    reply_len = 0;
    rx_bad    = 1'b0;
    errors    = 0;
    foreach (reply_buf[k]) reply_buf[k] = 8'h00;
  endfunction

  function bit busy();
    return phase != LINK_IDLE;
  endfunction

  function void owe(logic [1:0] kind, logic [7:0] b, logic [1:0] st);
    out_item_t r;
    r.kind     = kind;
    r.out_byte = b;
    r.status   = st;
    r.last     = 1'b0;
    results_due.insert(results_due.size(), r);
  endfunction

  function void send_tx(logic [7:0] b);
    tx_sum = tx_sum + b;
    owe(KIND_TX, b, ST_OK);
  endfunction

  function void send_checksum();
    owe(KIND_TX, ~tx_sum, ST_OK);
    phase = LINK_RECV;
  endfunction

  function void take_reply(logic [7:0] d);
    int total;
    total = reply_len + 6;
    if (rx_pos >= 2) rx_sum = rx_sum + d;
    if (rx_pos < 2 && d != 8'hFF) rx_bad = 1'b1;
    if (rx_pos == 2 && d != peer_id) rx_bad = 1'b1;
    if (rx_pos == 3 && d != 8'(reply_len + 2)) rx_bad = 1'b1;
    if (rx_pos == 4 && d != 8'h00) rx_bad = 1'b1;
    if (rx_pos >= 5 && rx_pos + 1 < total) reply_buf[rx_pos - 5] = d;
    rx_pos++;
    if (rx_pos < total) return;
    if (rx_sum != 8'hFF) rx_bad = 1'b1;
    phase = LINK_IDLE;
    if (rx_bad) begin
      owe(KIND_STATUS, 8'h00, ST_INVALID);
    end else begin
      owe(KIND_STATUS, 8'h00, ST_OK);
      for (int k = 0; k < reply_len; k++) owe(KIND_PARAM, reply_buf[k], ST_OK);
    end
  endfunction

  function void take_input(in_item_t it);
    int         owed_at_start;
    int         rc;
    logic [7:0] len_b;
    out_item_t  tail;
    owed_at_start = results_due.size();
    case (it.action)
      ACT_START: begin
        cmd_due   = (it.cmd_param_count > 16) ? 16 : it.cmd_param_count;
        rc        = (it.reply_param_count > 16) ? 16 : it.reply_param_count;
        len_b     = 8'(cmd_due + 2);
        peer_id   = it.target_id;
        reply_len = rc;
        rx_pos    = 0;
        rx_sum    = '0;
        rx_bad    = 1'b0;
        ticks     = '0;
        tx_sum    = '0;
        phase     = LINK_SEND;
        owe(KIND_TX, 8'hFF, ST_OK);
        owe(KIND_TX, 8'hFF, ST_OK);
        send_tx(it.target_id);
        send_tx(len_b);
        send_tx(it.instruction);
        if (cmd_due == 0) send_checksum();
      end
      ACT_PARAM: begin
        if (phase == LINK_SEND) begin
          send_tx(it.data_byte);
          if (cmd_due > 0) cmd_due--;
          if (cmd_due == 0) send_checksum();
        end
      end
      ACT_REPLY: begin
        if (phase == LINK_RECV) take_reply(it.data_byte);
      end
      ACT_TICK: begin
        if (phase != LINK_IDLE) begin
          if (ticks != 16'hFFFF) ticks++;
          if (ticks >= limit) begin
            phase = LINK_IDLE;
            owe(KIND_STATUS, 8'h00, ST_TIMEOUT);
          end
        end
      end
    endcase
    if (results_due.size() > owed_at_start) begin
      tail = results_due.pop_back();
      tail.last = 1'b1;
      results_due.insert(results_due.size(), tail);
    end
  endfunction

  function void same_field(string what, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
    end
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (results_due.size() == 0) begin
      errors++;
      $display("%0t: result with nothing owed, expected none, actual kind %0h byte %0h",
               $time, got.kind, got.out_byte);
      return;
    end
    want = results_due.pop_front();
    same_field("kind", 8'(want.kind), 8'(got.kind));
    same_field("out_byte", want.out_byte, got.out_byte);
    same_field("status", 8'(want.status), 8'(got.status));
    same_field("last", 8'(want.last), 8'(got.last));
  endfunction

  function int close_out();
    if (results_due.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived, expected kind %0h byte %0h, actual none",
               $time, results_due.size(), results_due[0].kind, results_due[0].out_byte);
    end
    return errors;
  endfunction
endclass

module tb_servo_packet_transaction;

  logic clk = 1'b0;
  logic rst_n;

  spt_in_if  in_ch ();
  spt_out_if out_ch ();
  spt_cfg_if cfg_ch ();

  servo_packet_transaction i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // An 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  servo_bus_tracker book;

  // Switches shared by the stimulus and the receiver. The quiet flags turn
  // off random idling on one side, so that some stretches run back to back.
  bit tx_quiet      = 1'b0;
  bit rx_quiet      = 1'b0;
  bit tick_mix      = 1'b0;
  bit tally_on      = 1'b0;
  int items_sent    = 0;
  int hold_requests = 0;

  // Gap lengths: mostly drawn from the smaller of two ranges, now and then a long pause.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    return (r < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Parameter counts stay small most of the time, so that transactions are
  // short, but the saturating range above sixteen is visited too.
  function automatic logic [4:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 5'($urandom_range(0, 4));
    if (r < 90) return 5'($urandom_range(5, 16));
    return 5'($urandom_range(17, 31));
  endfunction

  // Offers one input transfer and waits until the block takes it. Valid is
  // left high on return, so a caller that does not follow straight on with
  // another transfer must lower it in the same step.
  task automatic push(input in_item_t it);
    int gap;
    gap = 0;
    if (!tx_quiet && $urandom_range(0, 99) < 30) gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.action            <= it.action;
    in_ch.target_id         <= it.target_id;
    in_ch.instruction       <= it.instruction;
    in_ch.cmd_param_count   <= it.cmd_param_count;
    in_ch.reply_param_count <= it.reply_param_count;
    in_ch.data_byte         <= it.data_byte;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    book.take_input(it);
    if (tally_on) items_sent++;
  endtask

  task automatic send_start(input logic [7:0] id, input logic [7:0] instr,
                            input logic [4:0] cc, input logic [4:0] rc);
    in_item_t it;
    it.action            = ACT_START;
    it.target_id         = id;
    it.instruction       = instr;
    it.cmd_param_count   = cc;
    it.reply_param_count = rc;
    it.data_byte         = 8'($urandom_range(0, 255));
    push(it);
  endtask

  // Byte and tick transfers: the fields that only a start uses carry noise.
  task automatic send_byte(input logic [1:0] act, input logic [7:0] d);
    in_item_t it;
    it.action            = act;
    it.target_id         = 8'($urandom_range(0, 255));
    it.instruction       = 8'($urandom_range(0, 255));
    it.cmd_param_count   = 5'($urandom_range(0, 31));
    it.reply_param_count = 5'($urandom_range(0, 31));
    it.data_byte         = d;
    push(it);
  endtask

  task automatic maybe_tick();
    if (tick_mix && $urandom_range(0, 99) < 8) begin
      send_byte(ACT_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  // Sends a reply packet as a servo would: header, id, length, a zero error
  // byte, the parameters and the inverted sum. One byte may be spoilt by an
  // XOR mask, and the packet may be cut short after a given number of bytes.
  task automatic send_reply(input logic [7:0] id, input int re, input int flaw_pos,
                            input logic [7:0] flaw_mask, input int cut);
    logic [7:0] pkt [$];
    logic [7:0] sum;
    logic [7:0] b;
    int         n;
    pkt.insert(pkt.size(), 8'hFF);
    pkt.insert(pkt.size(), 8'hFF);
    pkt.insert(pkt.size(), id);
    b = 8'(re + 2);
    pkt.insert(pkt.size(), b);
    pkt.insert(pkt.size(), 8'h00);
    sum = id + b;
    for (int k = 0; k < re; k++) begin
      b = 8'($urandom_range(0, 255));
      pkt.insert(pkt.size(), b);
      sum = sum + b;
    end
    pkt.insert(pkt.size(), ~sum);
    if (flaw_pos >= 0) pkt[flaw_pos] = pkt[flaw_pos] ^ flaw_mask;
    n = (cut < 0 || cut > pkt.size()) ? pkt.size() : cut;
    for (int k = 0; k < n; k++) begin
      maybe_tick();
      send_byte(ACT_REPLY, pkt[k]);
    end
  endtask

  // One whole transaction: the start, its command parameters, and then
  // either a reply or a run of ticks until the block gives up waiting.
  task automatic run_exchange(input logic [7:0] id, input logic [7:0] instr,
                              input logic [4:0] cc, input logic [4:0] rc,
                              input int flaw_pos, input logic [7:0] flaw_mask,
                              input int cut, input bit wait_out);
    int ce;
    int re;
    int guard;
    ce = (cc > 16) ? 16 : cc;
    re = (rc > 16) ? 16 : rc;
    send_start(id, instr, cc, rc);
    for (int k = 0; k < ce; k++) begin
      maybe_tick();
      send_byte(ACT_PARAM, 8'($urandom_range(0, 255)));
    end
    if (wait_out) begin
      guard = 0;
      while (book.busy() && guard < 1000) begin
        send_byte(ACT_TICK, 8'($urandom_range(0, 255)));
        guard++;
      end
    end else begin
      send_reply(id, re, flaw_pos, flaw_mask, cut);
    end
  endtask

  // Most random transactions are well formed; the rest carry a spoilt byte,
  // are cut short (so the next start drops them), are left to time out, or
  // are plain noise with every field random.
  task automatic random_exchange();
    in_item_t   it;
    logic [4:0] cc;
    logic [4:0] rc;
    int         re;
    int         r;
    tx_quiet = ($urandom_range(0, 99) < 20);
    rx_quiet = ($urandom_range(0, 99) < 20);
    if ($urandom_range(0, 99) < 10) begin
      it.action            = 2'($urandom_range(0, 3));
      it.target_id         = 8'($urandom_range(0, 255));
      it.instruction       = 8'($urandom_range(0, 255));
      it.cmd_param_count   = 5'($urandom_range(0, 31));
      it.reply_param_count = 5'($urandom_range(0, 31));
      it.data_byte         = 8'($urandom_range(0, 255));
      tally_on = 1'b0;
      push(it);
      tally_on = 1'b1;
    end else begin
      cc = pick_count();
      rc = pick_count();
      re = (rc > 16) ? 16 : rc;
      r  = $urandom_range(0, 99);
      if (r < 60) begin
        run_exchange(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), cc, rc, -1,
                     8'h00, -1, 1'b0);
      end else if (r < 80) begin
        run_exchange(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), cc, rc,
                     $urandom_range(0, re + 5), 8'($urandom_range(1, 255)), -1, 1'b0);
      end else if (r < 92) begin
        run_exchange(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), cc, rc, -1,
                     8'h00, $urandom_range(0, re + 5), 1'b0);
      end else begin
        run_exchange(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), cc, rc, -1,
                     8'h00, -1, 1'b1);
      end
    end
  endtask

  // Lets the block drain: every owed result has to arrive, and then a few
  // more cycles pass for a transfer that produces no result to be finished.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (book.results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    settle();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.timeout_ticks <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    book.limit = v;
  endtask

  // Receiver: checks each result transfer and idles at random. A hold
  // request from the stimulus makes it refuse results for a long stretch,
  // counted here, so that the block's output fills and its intake stalls.
  initial begin : result_sink
    int        stall_left;
    int        hold_left;
    int        holds_seen;
    out_item_t got;
    stall_left   = 0;
    hold_left    = 0;
    holds_seen   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.kind     = out_ch.kind;
        got.out_byte = out_ch.out_byte;
        got.status   = out_ch.status;
        got.last     = out_ch.last;
        book.check_result(got);
      end
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!rx_quiet && $urandom_range(0, 99) < 25) stall_left = gap_len();
      end
    end
  end

  // Stimulus: directed transactions under the reset timeout, then the
  // timeout extremes, then random traffic under several timeout settings.
  initial begin : stimulus
    int drain;
    book = new();
    rst_n                    = 1'b0;
    in_ch.valid              = 1'b0;
    in_ch.action             = ACT_START;
    in_ch.target_id          = '0;
    in_ch.instruction        = '0;
    in_ch.cmd_param_count    = '0;
    in_ch.reply_param_count  = '0;
    in_ch.data_byte          = '0;
    cfg_ch.valid             = 1'b0;
    cfg_ch.timeout_ticks     = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Bytes and ticks while idle are all ignored.
    send_byte(ACT_PARAM, 8'hA5);
    send_byte(ACT_REPLY, 8'hFF);
    send_byte(ACT_TICK, 8'h00);
    // No command parameters: the checksum follows the header at once. A
    // command byte while waiting for the reply is ignored, then a good
    // reply without parameters completes the exchange.
    send_start(8'hFF, 8'hFF, 5'd0, 5'd0);
    send_byte(ACT_PARAM, 8'h5A);
    send_reply(8'hFF, 0, -1, 8'h00, -1);
    // Oversized counts saturate; a reply byte while still sending is
    // ignored; a second start drops the running transaction silently.
    send_start(8'h00, 8'h00, 5'd31, 5'd31);
    send_byte(ACT_REPLY, 8'h00);
    send_byte(ACT_TICK, 8'hFF);
    send_start(8'h01, 8'h80, 5'd1, 5'd1);
    send_byte(ACT_PARAM, 8'h00);
    // The servo reports an error, so the reply is invalid.
    send_reply(8'h01, 1, 4, 8'h01, -1);

    // The shortest timeout ends a transaction on its first tick; a command
    // byte after that finds the block idle.
    write_timeout(16'd1);
    send_start(8'h03, 8'hF0, 5'd2, 5'd0);
    send_byte(ACT_TICK, 8'h3C);
    send_byte(ACT_PARAM, 8'h11);

    // A zero limit also times out on the first tick.
    write_timeout(16'd0);
    send_start(8'h7F, 8'h01, 5'd0, 5'd3);
    send_byte(ACT_TICK, 8'hC3);
    send_byte(ACT_REPLY, 8'hFF);

    // The longest timeout: a few ticks leave the transaction running, and
    // the next start drops it without a status.
    write_timeout(16'hFFFF);
    send_start(8'h10, 8'h20, 5'd1, 5'd2);
    repeat (4) send_byte(ACT_TICK, 8'($urandom_range(0, 255)));

    tick_mix = 1'b1;
    tally_on = 1'b1;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: write_timeout(16'd24);
        1: write_timeout(16'($urandom_range(6, 12)));
        default: write_timeout(16'($urandom_range(14, 24)));
      endcase
      items_sent = 0;
      if (ph == 0) begin
        // Long receiver hold while a full-size exchange is being offered.
        hold_requests++;
        run_exchange(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 5'd16, 5'd16,
                     -1, 8'h00, -1, 1'b0);
      end
      while (items_sent < 15) random_exchange();
    end

    in_ch.valid <= 1'b0;
    drain = 0;
    while (book.results_due.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (book.close_out() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hang guard, well beyond the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### servo_packet_transaction.f
rtl/core/spt_pkg.sv
rtl/core/spt_ifs.sv
rtl/core/spt_dp.sv
rtl/core/spt_ctrl.sv
rtl/core/servo_packet_transaction.sv
tb/tb_servo_packet_transaction.sv
